/* rtl/sef_pkg.sv */
// Shared types, codes, rounding helper and sigmoid table for the SwiGLU expert block.
package sef_pkg;

    localparam logic [2:0] OP_GATE    = 3'd0;
    localparam logic [2:0] OP_UP      = 3'd1;
    localparam logic [2:0] OP_DOWN    = 3'd2;
    localparam logic [2:0] OP_INPUT   = 3'd3;
    localparam logic [2:0] OP_COMPUTE = 3'd4;

    localparam logic [1:0] CFG_MODEL_DIM  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN_DIM = 2'd1;
    localparam logic [1:0] CFG_LAYERS     = 2'd2;

    localparam logic [63:0] EXP_STEP = 64'd1008687096;

    typedef logic [12:0] sig_table_t [256];

    typedef struct packed {
        logic load;
        logic start;
        logic dot_start;
        logic dot_down;
        logic round_gu;
        logic silu_mul;
        logic silu_round;
        logic hid_mul;
        logic hid_write;
        logic emit;
        logic err_emit;
    } sef_cmd_t;

    typedef struct packed {
        logic layer_ok;
        logic dot_done;
        logic last_row;
        logic last_out;
        logic out_busy;
    } sef_status_t;

    // Round to nearest with ties upwards at bit 12, then saturate to 16 bits.
    function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v);
        logic signed [47:0] w;
        w = (v + 48'sd2048) >>> 12;
        if (w > 48'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (w < -48'sd32768)
        begin
            return 16'sh8000;
        end
        return w[15:0];
    endfunction

    // Sigmoid in Q0.12 over [-8,8) in steps of 1/16, built at elaboration.
    function automatic sig_table_t build_sig_table();
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [12:0] sp [129];
        sig_table_t t;
        e = 64'd1 << 30;
        for (int m = 0; m < 129; m++)
        begin
            den = (64'd1 << 30) + e;
            num = (64'd1 << 42) + (den >> 1);
            rem = '0;
            quo = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo[b] = 1'b1;
                end
            end
            sp[m] = quo[12:0];
            e = (e * EXP_STEP + (64'd1 << 29)) >> 30;
        end
        for (int k = 0; k < 256; k++)
        begin
            if (k >= 128)
            begin
                t[k] = sp[k - 128];
            end
            else
            begin
                t[k] = 13'd4096 - sp[128 - k];
            end
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

/* rtl/sef_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sef_ctrl.sv */
// Sequencing state machine for loads, the gate/up pass and the down pass.
module sef_ctrl
    import sef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  sef_status_t status,
    output sef_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ERR     = 4'd1;
    localparam logic [3:0] S_GU_RUN  = 4'd2;
    localparam logic [3:0] S_GU_WAIT = 4'd3;
    localparam logic [3:0] S_P1      = 4'd4;
    localparam logic [3:0] S_P2      = 4'd5;
    localparam logic [3:0] S_P3      = 4'd6;
    localparam logic [3:0] S_P4      = 4'd7;
    localparam logic [3:0] S_P5      = 4'd8;
    localparam logic [3:0] S_DN_RUN  = 4'd9;
    localparam logic [3:0] S_DN_WAIT = 4'd10;
    localparam logic [3:0] S_DN_OUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_COMPUTE)
                    begin
                        if (status.layer_ok)
                        begin
                            cmd.start = 1'b1;
                            state_next = S_GU_RUN;
                        end
                        else
                        begin
                            state_next = S_ERR;
                        end
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_ERR:
            begin
                if (!status.out_busy)
                begin
                    cmd.err_emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_GU_RUN:
            begin
                cmd.dot_start = 1'b1;
                state_next = S_GU_WAIT;
            end
            S_GU_WAIT:
            begin
                if (status.dot_done)
                begin
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                cmd.round_gu = 1'b1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.silu_mul = 1'b1;
                state_next = S_P3;
            end
            S_P3:
            begin
                cmd.silu_round = 1'b1;
                state_next = S_P4;
            end
            S_P4:
            begin
                cmd.hid_mul = 1'b1;
                state_next = S_P5;
            end
            S_P5:
            begin
                cmd.hid_write = 1'b1;
                state_next = status.last_row ? S_DN_RUN : S_GU_RUN;
            end
            S_DN_RUN:
            begin
                cmd.dot_start = 1'b1;
                cmd.dot_down = 1'b1;
                state_next = S_DN_WAIT;
            end
            S_DN_WAIT:
            begin
                if (status.dot_done)
                begin
                    state_next = S_DN_OUT;
                end
            end
            S_DN_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = status.last_out ? S_IDLE : S_DN_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/sef_datapath.sv */
// Weight stores, dot-product pipeline, silu stage and output register.
module sef_datapath
    import sef_pkg::*;
#(
    parameter int MODEL_DIM  = 32,
    parameter int HIDDEN_DIM = 64,
    parameter int LAYERS     = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic [2:0]         op,
    input  logic               layer,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [15:0] value,
    input  sef_cmd_t           cmd,
    output sef_status_t        status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         out_index,
    output logic signed [15:0] out_value,
    output logic               last,
    output logic               error
);

    localparam int WDEPTH = LAYERS * HIDDEN_DIM * MODEL_DIM;
    localparam int AW     = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
    localparam int MIW    = MODEL_DIM > 1 ? $clog2(MODEL_DIM) : 1;
    localparam int HIW    = HIDDEN_DIM > 1 ? $clog2(HIDDEN_DIM) : 1;
    localparam int MCW    = $clog2(MODEL_DIM + 1);
    localparam int HCW    = $clog2(HIDDEN_DIM + 1);
    localparam int KW     = MCW > HCW ? MCW : HCW;
    localparam int STRIDE = HIDDEN_DIM * MODEL_DIM;

    logic [5:0] model_dim_used_reg;
    logic [6:0] hidden_dim_used_reg;
    logic [1:0] layers_used_reg;

    logic [KW-1:0] d_clamp;
    logic [KW-1:0] h_clamp;
    logic [KW-1:0] d_reg;
    logic [KW-1:0] h_reg;
    logic [AW-1:0] gu_base_reg;
    logic [AW-1:0] dn_base_reg;
    logic [KW-1:0] j_reg;
    logic [KW-1:0] i_reg;

    logic          run_reg;
    logic          mode_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] len;
    logic          rd_v_reg;
    logic          rd_last_reg;
    logic          mul_v_reg;
    logic          mul_last_reg;
    logic          done_reg;
    logic signed [31:0] pa_reg;
    logic signed [31:0] pb_reg;
    logic signed [39:0] acc_a_reg;
    logic signed [39:0] acc_b_reg;

    logic signed [15:0] g_reg;
    logic signed [15:0] u_reg;
    logic signed [29:0] p1_reg;
    logic signed [15:0] silu_reg;
    logic signed [31:0] p2_reg;
    logic [12:0]        sig;

    logic               out_valid_reg;
    logic [4:0]         out_index_reg;
    logic signed [15:0] out_value_reg;
    logic               last_reg;
    logic               error_reg;

    logic [AW-1:0]  gu_waddr;
    logic [AW-1:0]  dn_waddr;
    logic           gate_we;
    logic           up_we;
    logic           down_we;
    logic           in_we;
    logic [15:0]    gate_rd;
    logic [15:0]    up_rd;
    logic [15:0]    down_rd;
    logic [15:0]    x_rd;
    logic [15:0]    hid_rd;

    // Load addressing and bounds.
    assign gu_waddr = AW'((32'(layer) * HIDDEN_DIM + 32'(row)) * MODEL_DIM + 32'(col));
    assign dn_waddr = AW'((32'(layer) * MODEL_DIM + 32'(row)) * HIDDEN_DIM + 32'(col));
    assign gate_we = cmd.load && (op == OP_GATE) && (32'(layer) < LAYERS)
                     && (32'(row) < HIDDEN_DIM) && (32'(col) < MODEL_DIM);
    assign up_we   = cmd.load && (op == OP_UP) && (32'(layer) < LAYERS)
                     && (32'(row) < HIDDEN_DIM) && (32'(col) < MODEL_DIM);
    assign down_we = cmd.load && (op == OP_DOWN) && (32'(layer) < LAYERS)
                     && (32'(row) < MODEL_DIM) && (32'(col) < HIDDEN_DIM);
    assign in_we   = cmd.load && (op == OP_INPUT) && (32'(col) < MODEL_DIM);

    sef_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_gate (
        .clk(clk), .we(gate_we), .waddr(gu_waddr), .wdata(value),
        .raddr(gu_base_reg + AW'(k_reg)), .rdata(gate_rd)
    );
    sef_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_up (
        .clk(clk), .we(up_we), .waddr(gu_waddr), .wdata(value),
        .raddr(gu_base_reg + AW'(k_reg)), .rdata(up_rd)
    );
    sef_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_down (
        .clk(clk), .we(down_we), .waddr(dn_waddr), .wdata(value),
        .raddr(dn_base_reg + AW'(k_reg)), .rdata(down_rd)
    );
    sef_ram #(.WIDTH(16), .DEPTH(MODEL_DIM)) u_input (
        .clk(clk), .we(in_we), .waddr(col[MIW-1:0]), .wdata(value),
        .raddr(k_reg[MIW-1:0]), .rdata(x_rd)
    );
    sef_ram #(.WIDTH(16), .DEPTH(HIDDEN_DIM)) u_hidden (
        .clk(clk), .we(cmd.hid_write), .waddr(j_reg[HIW-1:0]),
        .wdata(rnd_sat(48'(p2_reg))), .raddr(k_reg[HIW-1:0]), .rdata(hid_rd)
    );

    always_comb
    begin
        if (model_dim_used_reg == '0)
        begin
            d_clamp = KW'(1);
        end
        else if (32'(model_dim_used_reg) > MODEL_DIM)
        begin
            d_clamp = KW'(MODEL_DIM);
        end
        else
        begin
            d_clamp = KW'(model_dim_used_reg);
        end
        if (hidden_dim_used_reg == '0)
        begin
            h_clamp = KW'(1);
        end
        else if (32'(hidden_dim_used_reg) > HIDDEN_DIM)
        begin
            h_clamp = KW'(HIDDEN_DIM);
        end
        else
        begin
            h_clamp = KW'(hidden_dim_used_reg);
        end
    end

    assign len = mode_reg ? h_reg : d_reg;
    // The sigmoid index is floor(g/256)+128, i.e. the top byte with its sign bit flipped.
    assign sig = SIG_TABLE[{~g_reg[15], g_reg[14:8]}];

    assign status.layer_ok = ({1'b0, layer} < layers_used_reg) && (32'(layer) < LAYERS);
    assign status.dot_done = done_reg;
    assign status.last_row = (j_reg == h_reg - KW'(1));
    assign status.last_out = (i_reg == d_reg - KW'(1));
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_dim_used_reg  <= 6'd32;
            hidden_dim_used_reg <= 7'd64;
            layers_used_reg     <= 2'd2;
            run_reg       <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODEL_DIM:  model_dim_used_reg  <= cfg_data[5:0];
                    CFG_HIDDEN_DIM: hidden_dim_used_reg <= cfg_data;
                    CFG_LAYERS:     layers_used_reg     <= cfg_data[1:0];
                    default:        ;
                endcase
            end
            if (cmd.dot_start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && k_reg == len - KW'(1))
            begin
                run_reg <= 1'b0;
            end
            rd_v_reg     <= run_reg && !cmd.dot_start;
            rd_last_reg  <= run_reg && !cmd.dot_start && (k_reg == len - KW'(1));
            mul_v_reg    <= rd_v_reg;
            mul_last_reg <= rd_last_reg;
            done_reg     <= mul_v_reg && mul_last_reg;
            if (cmd.emit || cmd.err_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            d_reg       <= d_clamp;
            h_reg       <= h_clamp;
            gu_base_reg <= layer ? AW'(STRIDE) : '0;
            dn_base_reg <= layer ? AW'(STRIDE) : '0;
            j_reg       <= '0;
            i_reg       <= '0;
        end
        if (cmd.dot_start)
        begin
            k_reg     <= '0;
            mode_reg  <= cmd.dot_down;
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end
        else
        begin
            if (run_reg)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (mul_v_reg)
            begin
                acc_a_reg <= acc_a_reg + 40'(pa_reg);
                acc_b_reg <= acc_b_reg + 40'(pb_reg);
            end
        end
        if (mode_reg)
        begin
            pa_reg <= 32'($signed(down_rd)) * 32'($signed(hid_rd));
        end
        else
        begin
            pa_reg <= 32'($signed(gate_rd)) * 32'($signed(x_rd));
        end
        pb_reg <= 32'($signed(up_rd)) * 32'($signed(x_rd));
        if (cmd.round_gu)
        begin
            g_reg <= rnd_sat(48'(acc_a_reg));
            u_reg <= rnd_sat(48'(acc_b_reg));
        end
        if (cmd.silu_mul)
        begin
            p1_reg <= 30'(g_reg) * 30'($signed({1'b0, sig}));
        end
        if (cmd.silu_round)
        begin
            silu_reg <= rnd_sat(48'(p1_reg));
        end
        if (cmd.hid_mul)
        begin
            p2_reg <= 32'(silu_reg) * 32'(u_reg);
        end
        if (cmd.hid_write)
        begin
            j_reg       <= j_reg + KW'(1);
            gu_base_reg <= gu_base_reg + AW'(MODEL_DIM);
        end
        if (cmd.emit)
        begin
            out_index_reg <= 5'(i_reg);
            out_value_reg <= rnd_sat(48'(acc_a_reg));
            last_reg      <= (i_reg == d_reg - KW'(1));
            error_reg     <= 1'b0;
            i_reg         <= i_reg + KW'(1);
            dn_base_reg   <= dn_base_reg + AW'(HIDDEN_DIM);
        end
        if (cmd.err_emit)
        begin
            out_index_reg <= '0;
            out_value_reg <= '0;
            last_reg      <= 1'b1;
            error_reg     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

/* rtl/swiglu_expert_ffn.sv */
// Top level of the SwiGLU expert feed-forward block.
//
// Requests arrive on the input channel (in_valid/in_ready) with op, layer,
// row, col and value. Load requests (gate, up, down weight or input element)
// are taken one per cycle while idle and give no result; out-of-range loads are dropped.
// A compute request closes intake until the layer has been walked.
// For each hidden row the gate/up dot product runs through the store read,
// product register and accumulator, followed by rounding, the silu table
// multiply and the hidden write. Each output element then runs a dot product
// through the down-weight store; each weight memory has a single read port.
// Results leave in index order through an output register (out_valid/out_ready)
// with last on the final element; an invalid layer gives one result with error
// set. A stalled receiver holds the next element back until the register
// empties; loads are still taken meanwhile once the compute has finished.
// Reset restores the configuration registers to 32, 64 and 2 and clears the
// handshake state; stores are not cleared. Configuration is written through
// cfg_write/cfg_index/cfg_data; the user must write it only while idle, as the
// block itself does not enforce this.
module swiglu_expert_ffn
    import sef_pkg::*;
#(
    parameter int MODEL_DIM  = 32,
    parameter int HIDDEN_DIM = 64,
    parameter int LAYERS     = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic               layer,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         out_index,
    output logic signed [15:0] out_value,
    output logic               last,
    output logic               error
);

    sef_cmd_t    cmd;
    sef_status_t status;

    sef_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .status(status), .cmd(cmd)
    );

    sef_datapath #(
        .MODEL_DIM(MODEL_DIM), .HIDDEN_DIM(HIDDEN_DIM), .LAYERS(LAYERS)
    ) u_datapath (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .op(op), .layer(layer), .row(row), .col(col), .value(value),
        .cmd(cmd), .status(status),
        .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
        .out_value(out_value), .last(last), .error(error)
    );

endmodule
